>>> sv/qph_pkg.sv
package qph_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);
   localparam int IDX_W      = ADDR_W + 1;
   localparam int KEY_W      = 64;
   localparam int VALUE_W    = 64;
   localparam int ENTRY_W    = 1 + KEY_W + VALUE_W;
   localparam int HASH_W     = 10;
   localparam int COUNT_W    = 11;

   localparam logic [0:0] FUNC_INSERT = 1'b0;
   localparam logic [0:0] FUNC_LOOKUP = 1'b1;

   localparam logic [2:0] STATUS_NEW  = 3'd0;
   localparam logic [2:0] STATUS_OVER = 3'd1;
   localparam logic [2:0] STATUS_HIT  = 3'd2;
   localparam logic [2:0] STATUS_MISS = 3'd3;
   localparam logic [2:0] STATUS_FULL = 3'd4;

   localparam logic [COUNT_W-1:0] MAX_FILL_RESET = 11'd512;

   typedef struct packed {
      logic [0:0]         func;
      logic [HASH_W-1:0]  hash;
      logic [63:0]        key;
      logic [63:0]        value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               hit;
      logic [63:0]        found_value;
      logic [63:0]        stored_key;
      logic [COUNT_W-1:0] item_total;
   } rsp_type;

endpackage

>>> sv/quadratic_probe_hash_table_unit.sv
// channel  | ports                          | direction | payload
// request  | req_valid, req_ready, req_data | in        | qph_pkg::req_type
// response | rsp_valid, rsp_ready, rsp_data | out       | qph_pkg::rsp_type
// config   | csr_wr_en, csr_wr_data         | in        | max_fill, 11 bits
//
// An item is probed bucket by bucket from accept to result (one bucket read
// of the table per cycle while no result stalls it; the table has a read
// port and a separate write port); the next item is taken in the cycle after
// the result is loaded. After reset a clearing pass zeroes all 1024 entries;
// no item is taken during it. A result waiting at the output stalls probing only.
module quadratic_probe_hash_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  qph_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output qph_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [qph_pkg::COUNT_W-1:0]       csr_wr_data
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;
   localparam logic [1:0] ST_CHECK = 2'd3;

   localparam logic [qph_pkg::ADDR_W-1:0] LAST_ADDR =
      qph_pkg::ADDR_W'(qph_pkg::TABLE_SIZE - 1);
   localparam logic [qph_pkg::IDX_W-1:0]  LAST_IDX  =
      qph_pkg::IDX_W'(qph_pkg::TABLE_SIZE - 1);

   logic [qph_pkg::ENTRY_W-1:0] mem [qph_pkg::TABLE_SIZE];
   logic [qph_pkg::ENTRY_W-1:0] rd_data_ff;

   logic [1:0]                   state_ff, state_in;
   logic [qph_pkg::ADDR_W-1:0]   clr_ff;
   logic [qph_pkg::ADDR_W-1:0]   slot_ff, chk_slot_ff;
   logic [qph_pkg::IDX_W-1:0]    idx_ff, chk_idx_ff;
   logic [qph_pkg::COUNT_W-1:0]  count_ff, max_fill_ff;
   logic                         rsp_valid_ff;
   qph_pkg::req_type             req_ff;
   qph_pkg::rsp_type             rsp_ff, rsp_in;

   logic                         out_free, stall, advance, done, insert;
   logic                         rd_valid, match, empty, last, add_new, wr_en;
   logic [qph_pkg::KEY_W-1:0]    rd_key, req_key;
   logic [qph_pkg::VALUE_W-1:0]  rd_value, req_value;
   logic [qph_pkg::ADDR_W-1:0]   rd_addr, wr_addr, slot_step;
   logic [qph_pkg::ENTRY_W-1:0]  wr_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stall     = (state_ff == ST_CHECK) && !out_free;
   assign advance   = (state_ff == ST_ISSUE) || ((state_ff == ST_CHECK) && out_free);

   assign rd_valid  = rd_data_ff[qph_pkg::ENTRY_W-1];
   assign rd_key    = rd_data_ff[qph_pkg::KEY_W+qph_pkg::VALUE_W-1 -: qph_pkg::KEY_W];
   assign rd_value  = rd_data_ff[qph_pkg::VALUE_W-1:0];
   assign req_key   = req_ff.key[qph_pkg::KEY_W-1:0];
   assign req_value = req_ff.value[qph_pkg::VALUE_W-1:0];
   assign insert    = (req_ff.func == qph_pkg::FUNC_INSERT);

   assign empty     = !rd_valid;
   assign match     = rd_valid && (rd_key == req_key);
   assign last      = (chk_idx_ff == LAST_IDX);
   assign done      = (state_ff == ST_CHECK) && out_free && (empty || match || last);
   assign add_new   = done && empty && insert && (count_ff < max_fill_ff);

   // probe offset i/2 + i*i/2 grows by i after an even i, by i + 2 after an odd i
   assign slot_step = idx_ff[qph_pkg::ADDR_W-1:0] +
                      qph_pkg::ADDR_W'({idx_ff[0], 1'b0});

   assign rd_addr   = stall ? chk_slot_ff : slot_ff;
   assign wr_en     = (state_ff == ST_CLEAR) || add_new || (done && match && insert);
   assign wr_addr   = (state_ff == ST_CLEAR) ? clr_ff : chk_slot_ff;
   assign wr_data   = (state_ff == ST_CLEAR) ? '0 : {1'b1, req_key, req_value};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      rsp_in            = '0;
      rsp_in.item_total = add_new ? count_ff + 1'b1 : count_ff;
      priority if (match) begin
         rsp_in.status      = insert ? qph_pkg::STATUS_OVER : qph_pkg::STATUS_HIT;
         rsp_in.hit         = 1'b1;
         rsp_in.found_value = 64'(insert ? req_value : rd_value);
         rsp_in.stored_key  = 64'(rd_key);
      end else if (add_new) begin
         rsp_in.status      = qph_pkg::STATUS_NEW;
         rsp_in.hit         = 1'b1;
         rsp_in.found_value = 64'(req_value);
         rsp_in.stored_key  = 64'(req_key);
      end else begin
         rsp_in.status      = insert ? qph_pkg::STATUS_FULL : qph_pkg::STATUS_MISS;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         max_fill_ff  <= qph_pkg::MAX_FILL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (add_new) begin
            count_ff <= count_ff + 1'b1;
         end
         if (csr_wr_en) begin
            max_fill_ff <= csr_wr_data;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff  <= req_data;
         slot_ff <= qph_pkg::ADDR_W'(req_data.hash);
         idx_ff  <= '0;
      end else if (advance) begin
         chk_slot_ff <= slot_ff;
         chk_idx_ff  <= idx_ff;
         slot_ff     <= slot_ff + slot_step;
         idx_ff      <= idx_ff + 1'b1;
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> sv/qph_checker.sv
module qph_assertions (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input qph_pkg::rsp_type             rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response item changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item taken while one is in work");

   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hit == (rsp_data.status == qph_pkg::STATUS_NEW ||
                                     rsp_data.status == qph_pkg::STATUS_OVER ||
                                     rsp_data.status == qph_pkg::STATUS_HIT))
      else $error("hit flag disagrees with status");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == qph_pkg::STATUS_MISS ||
                    rsp_data.status == qph_pkg::STATUS_FULL)
      |-> rsp_data.found_value == 64'd0 && rsp_data.stored_key == 64'd0)
      else $error("miss or refusal carries nonzero data");

endmodule

bind quadratic_probe_hash_table_unit qph_assertions u_qph_assertions (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> dv/qph_checker.sv
`timescale 1ns / 1ps

module qph_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  qph_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  qph_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [qph_pkg::COUNT_W-1:0]   csr_wr_data,
   output int                            pending,
   output int                            fail_count
);

   logic [qph_pkg::KEY_W-1:0]   slot_key   [qph_pkg::TABLE_SIZE];
   logic [qph_pkg::VALUE_W-1:0] slot_value [qph_pkg::TABLE_SIZE];
   bit                          slot_used  [qph_pkg::TABLE_SIZE];
   logic [qph_pkg::COUNT_W-1:0] key_count;
   logic [qph_pkg::COUNT_W-1:0] fill_limit;
   qph_pkg::rsp_type            result_q [$];
   qph_pkg::rsp_type            want;
   int                          errors = 0;

   assign fail_count = errors;

   function automatic qph_pkg::rsp_type probe_table(input qph_pkg::req_type rq);
      qph_pkg::rsp_type r;
      bit      lookup;
      bit      done;
      int      i;
      int      pos;
      lookup = (rq.func == qph_pkg::FUNC_LOOKUP);
      done = 1'b0;
      r = '0;
      r.status = lookup ? qph_pkg::STATUS_MISS : qph_pkg::STATUS_FULL;
      for (i = 0; i < qph_pkg::TABLE_SIZE && !done; i++) begin
         pos = (int'(rq.hash) + i / 2 + i * i / 2) % qph_pkg::TABLE_SIZE;
         if (!slot_used[pos]) begin
            if (!lookup && key_count < fill_limit) begin
               slot_used[pos]  = 1'b1;
               slot_key[pos]   = rq.key;
               slot_value[pos] = rq.value;
               key_count = key_count + 1'b1;
               r.status = qph_pkg::STATUS_NEW;
               r.hit = 1'b1;
               r.found_value = rq.value;
               r.stored_key = rq.key;
            end
            done = 1'b1;
         end else if (slot_key[pos] == rq.key) begin
            if (!lookup) begin
               slot_value[pos] = rq.value;
               r.status = qph_pkg::STATUS_OVER;
            end else begin
               r.status = qph_pkg::STATUS_HIT;
            end
            r.hit = 1'b1;
            r.found_value = slot_value[pos];
            r.stored_key = slot_key[pos];
            done = 1'b1;
         end
      end
      r.item_total = key_count;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         errors++;
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (slot_used[j]) slot_used[j] = 1'b0;
         key_count = '0;
         fill_limit = qph_pkg::MAX_FILL_RESET;
         result_q.delete();
      end else begin
         if (csr_wr_en) fill_limit = csr_wr_data;
         if (req_valid && req_ready) result_q.push_back(probe_table(req_data));
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               errors++;
               $error("result with no item outstanding, status %0d", rsp_data.status);
            end else begin
               want = result_q.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("hit", 64'(want.hit), 64'(rsp_data.hit));
               check_field("found_value", want.found_value, rsp_data.found_value);
               check_field("stored_key", want.stored_key, rsp_data.stored_key);
               check_field("item_total", 64'(want.item_total), 64'(rsp_data.item_total));
            end
         end
      end
      pending <= result_q.size();
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   qph_pkg::req_type             req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   qph_pkg::rsp_type             rsp_data;
   logic                         csr_wr_en = 1'b0;
   logic [qph_pkg::COUNT_W-1:0]  csr_wr_data = '0;
   int                           pending;
   int                           fail_count;

   bit                           idle_on = 1'b1;
   int                           stall_left = 0;
   logic [63:0]                  pool_key [$];
   logic [qph_pkg::HASH_W-1:0]   pool_hash [$];

   quadratic_probe_hash_table_unit dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_wr_en, .csr_wr_data
   );

   qph_checker u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_wr_en, .csr_wr_data,
      .pending (pending),
      .fail_count (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 6) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [qph_pkg::HASH_W-1:0] rand_hash();
      if ($urandom_range(0, 3) == 0) return qph_pkg::HASH_W'($urandom_range(0, 31));
      return qph_pkg::HASH_W'($urandom_range(0, qph_pkg::TABLE_SIZE - 1));
   endfunction

   task automatic send_op(input logic [0:0] func, input logic [qph_pkg::HASH_W-1:0] hash,
                          input logic [63:0] key, input logic [63:0] value);
      qph_pkg::req_type item;
      int      gap;
      item.func = func;
      item.hash = hash;
      item.key = key;
      item.value = value;
      if (func == qph_pkg::FUNC_INSERT) begin
         pool_key.push_back(key);
         pool_hash.push_back(hash);
      end
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_max_fill(input logic [qph_pkg::COUNT_W-1:0] fill);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= fill;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int pick;
      int idx;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         idx = $urandom_range(0, pool_key.size() - 1);
         if (pick < 35)
            send_op(qph_pkg::FUNC_INSERT, rand_hash(), rand64(), rand64());
         else if (pick < 55)
            send_op(qph_pkg::FUNC_INSERT, pool_hash[idx], pool_key[idx], rand64());
         else if (pick < 85)
            send_op(qph_pkg::FUNC_LOOKUP, pool_hash[idx], pool_key[idx], rand64());
         else if (pick < 95)
            send_op(qph_pkg::FUNC_LOOKUP, rand_hash(), rand64(), rand64());
         else
            send_op($urandom_range(0, 1) ? qph_pkg::FUNC_LOOKUP : qph_pkg::FUNC_INSERT,
                    qph_pkg::HASH_W'($urandom), pool_key[idx], rand64());
      end
   endtask

   initial begin
      int h;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_op(qph_pkg::FUNC_LOOKUP, '0, '0, '0);
      send_op(qph_pkg::FUNC_INSERT, '0, '0, '1);
      send_op(qph_pkg::FUNC_INSERT, '1, '1, '0);
      send_op(qph_pkg::FUNC_LOOKUP, '0, '0, '0);
      send_op(qph_pkg::FUNC_LOOKUP, '1, '1, '1);
      send_op(qph_pkg::FUNC_INSERT, '0, '0, 64'h5555_5555_5555_5555);
      send_op(qph_pkg::FUNC_INSERT, '0, 64'hA5A5_A5A5_A5A5_A5A5, 64'h0123_4567_89AB_CDEF);
      send_op(qph_pkg::FUNC_INSERT, '0, 64'h5A5A_5A5A_5A5A_5A5A, 64'hFEDC_BA98_7654_3210);
      send_op(qph_pkg::FUNC_LOOKUP, '0, 64'h5A5A_5A5A_5A5A_5A5A, '0);
      send_op(qph_pkg::FUNC_LOOKUP, '0, 64'h1234, '0);
      send_op(qph_pkg::FUNC_INSERT, '1, '1, 64'hAAAA_AAAA_AAAA_AAAA);
      send_op(qph_pkg::FUNC_INSERT, '1, 64'd7, 64'h8000_0000_0000_0001);
      send_op(qph_pkg::FUNC_LOOKUP, '1, 64'd7, '0);
      send_op(qph_pkg::FUNC_LOOKUP, 10'd5, '0, '0);

      set_max_fill(11'd5);
      send_op(qph_pkg::FUNC_INSERT, 10'd100, 64'h99, 64'h42);
      send_op(qph_pkg::FUNC_INSERT, '0, 64'hA5A5_A5A5_A5A5_A5A5, '1);
      send_op(qph_pkg::FUNC_LOOKUP, 10'd100, 64'h99, '0);

      set_max_fill(11'd0);
      send_op(qph_pkg::FUNC_INSERT, 10'd512, 64'hDEAD_BEEF_0000_0001, 64'h1);
      send_op(qph_pkg::FUNC_LOOKUP, '0, '0, '0);

      set_max_fill(11'd200);
      run_random(300);
      set_max_fill(11'd60);
      run_random(150);
      set_max_fill(11'd1024);
      idle_on = 1'b0;
      run_random(100);
      idle_on = 1'b1;
      run_random(250);
      set_max_fill(11'd700);
      run_random(100);

      set_max_fill(11'd1024);
      idle_on = 1'b0;
      for (h = 0; h < qph_pkg::TABLE_SIZE; h++)
         send_op(qph_pkg::FUNC_INSERT, qph_pkg::HASH_W'(h), rand64(), rand64());
      send_op(qph_pkg::FUNC_INSERT, 10'd77, {$urandom, $urandom}, rand64());
      send_op(qph_pkg::FUNC_LOOKUP, 10'd300, {$urandom, $urandom}, rand64());
      run_random(20);
      set_max_fill(11'd0);
      run_random(10);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> filelist.f
sv/qph_pkg.sv
sv/quadratic_probe_hash_table_unit.sv
sv/qph_checker.sv
dv/qph_checker.sv
dv/tb_top.sv
